// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define FSED_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fsed check failed");

// checked on every rising edge
`define FSED_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fsed check failed");

`endif

// ===== hw/rtl/fsed_pkg.sv =====
// ----------------------------------------------------------------------------
// fsed_pkg
// types and constants of the escape stuffed frame decoder
// ----------------------------------------------------------------------------
package fsed_pkg;

  localparam int MaxFrameDef = 64;

  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 32;
  localparam logic [CfgAddrW-1:0] RegMaxPayload = 2'd0;
  localparam logic [6:0] MaxPayloadRst = 7'd38;

  localparam logic [7:0] ByteSof    = 8'hFF;
  localparam logic [7:0] ByteEof    = 8'hFE;
  localparam logic [7:0] ByteEsc    = 8'hF7;
  localparam logic [7:0] ByteEscSof = 8'h7F;
  localparam logic [7:0] ByteEscEof = 8'h7E;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    logic [6:0] frame_length;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } dec_t;

  function automatic res_t make_res(logic [7:0] b, kind_t k, logic [6:0] len, logic lst);
    res_t r;
    r.out_byte     = b;
    r.kind         = k;
    r.frame_length = len;
    r.last         = lst;
    return r;
  endfunction

endpackage

// ===== hw/rtl/fsed_if.sv =====
// ----------------------------------------------------------------------------
// fsed_in_if / fsed_out_if
// valid/ready channels for raw bytes and decoded results
// ----------------------------------------------------------------------------
interface fsed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fsed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [6:0] frame_length;
  logic       last;

  modport source (output valid, output out_byte, output kind, output frame_length,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input frame_length,
                  input last, output ready);
endinterface

// ===== hw/rtl/escape_stuffed_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// escape_stuffed_frame_decoder_top
// deframes 0xff/0xfe delimited, 0xf7 escaped byte streams
//
//   channel  dir  payload                              handshake
//   in_ch    in   rx_byte                              valid/ready
//   out_ch   out  out_byte, kind, frame_length, last   valid/ready
//   cfg      in   max_payload at byte address 0        apb, pready tied high
//
// one raw byte accepted per cycle unless out_ch stalls; results pass the
// input register, then the result register, which drains one request per
// cycle while out_ch.ready is high; bytes with results wait until it frees
// reset: synchronous on rst_n, frame hunt restarts, limit returns to 38
// stalls on out_ch back up through the result register into in_ch.ready
// ----------------------------------------------------------------------------
module escape_stuffed_frame_decoder_top #(
  parameter int MAX_FRAME = fsed_pkg::MaxFrameDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fsed_in_if.sink                        in_ch,
  fsed_out_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fsed_pkg::CfgAddrW-1:0]  paddr,
  input  logic [fsed_pkg::CfgDataW-1:0]  pwdata,
  output logic [fsed_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready
);
  import fsed_pkg::*;

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] byte_r;
  logic       acc, adv, free;
  logic [6:0] max_payload;
  dec_t       dec;
  res_t       head;

  fsed_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_payload (max_payload)
  );

  fsed_decode #(.MAX_FRAME(MAX_FRAME)) u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .rx_byte     (byte_r),
    .commit      (adv),
    .max_payload (max_payload),
    .dec         (dec)
  );

  fsed_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && (dec.n != 2'd0)),
    .dec       (dec),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .head      (head),
    .free      (free)
  );

  assign adv         = in_vld_r && ((dec.n == 2'd0) || free);
  assign in_ch.ready = !in_vld_r || adv;
  assign acc         = in_ch.valid && in_ch.ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (acc) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  assign out_ch.out_byte     = head.out_byte;
  assign out_ch.kind         = head.kind;
  assign out_ch.frame_length = head.frame_length;
  assign out_ch.last         = head.last;
endmodule

// ===== hw/rtl/fsed_cfg.sv =====
// ----------------------------------------------------------------------------
// fsed_cfg
// apb register file holding the payload limit
// ----------------------------------------------------------------------------
module fsed_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fsed_pkg::CfgAddrW-1:0]  paddr,
  input  logic [fsed_pkg::CfgDataW-1:0]  pwdata,
  output logic [fsed_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready,
  output logic [6:0]                     max_payload
);
  import fsed_pkg::*;

  logic [6:0] max_payload_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == RegMaxPayload);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MaxPayloadRst;
    end else if (wr_en) begin
      max_payload_r <= pwdata[6:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == RegMaxPayload) begin
      prdata = {{(CfgDataW-7){1'b0}}, max_payload_r};
    end
  end

  assign max_payload = max_payload_r;
endmodule

// ===== hw/rtl/fsed_decode.sv =====
// ----------------------------------------------------------------------------
// fsed_decode
// frame state and single pass decode of one raw byte into up to two results
// ----------------------------------------------------------------------------
module fsed_decode #(
  parameter int MAX_FRAME = fsed_pkg::MaxFrameDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       rx_byte,
  input  logic             commit,
  input  logic [6:0]       max_payload,
  output fsed_pkg::dec_t   dec
);
  import fsed_pkg::*;

  localparam logic [7:0] MaxFrameB = 8'(MAX_FRAME);

  logic       in_frame_r, in_frame_nxt;
  logic       esc_r, esc_nxt;
  logic [6:0] cnt_r, cnt_nxt;

  logic [7:0] lim;
  logic [6:0] cnt_inc;
  logic       ovf0, ovf1;
  logic       emit1;
  logic [7:0] ebyte;

  assign lim     = ({1'b0, max_payload} < MaxFrameB) ? {1'b0, max_payload} : MaxFrameB;
  assign cnt_inc = cnt_r + 7'd1;
  assign ovf0    = {1'b0, cnt_r} >= lim;
  assign ovf1    = {1'b0, cnt_inc} >= lim;

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    cnt_nxt      = cnt_r;
    dec          = '0;
    emit1        = 1'b0;
    ebyte        = rx_byte;

    if (!in_frame_r) begin
      if (rx_byte == ByteSof) begin
        in_frame_nxt = 1'b1;
        esc_nxt      = 1'b0;
        cnt_nxt      = '0;
      end
    end else if (esc_r) begin
      esc_nxt = 1'b0;
      priority if (rx_byte == ByteEscSof) begin
        emit1 = 1'b1;
        ebyte = ByteSof;
      end else if (rx_byte == ByteEscEof) begin
        emit1 = 1'b1;
        ebyte = ByteEof;
      end else if (rx_byte == ByteEsc) begin
        emit1 = 1'b1;
        ebyte = ByteEsc;
      end else if (rx_byte == ByteSof) begin
        dec.n        = 2'd1;
        dec.r0       = make_res(8'd0, KIND_ABORT, 7'd0, 1'b1);
        in_frame_nxt = 1'b1;
        cnt_nxt      = '0;
      end else if (ovf0) begin
        dec.n        = 2'd1;
        dec.r0       = make_res(8'd0, KIND_ABORT, 7'd0, 1'b1);
        in_frame_nxt = 1'b0;
        cnt_nxt      = '0;
      end else if (rx_byte == ByteEof) begin
        dec.n        = 2'd2;
        dec.r0       = make_res(ByteEsc, KIND_DATA, 7'd0, 1'b0);
        dec.r1       = make_res(8'd0, KIND_DONE, cnt_inc, 1'b1);
        in_frame_nxt = 1'b0;
        cnt_nxt      = '0;
      end else if (ovf1) begin
        // escape byte fits, the byte after it overflows
        dec.n        = 2'd2;
        dec.r0       = make_res(ByteEsc, KIND_DATA, 7'd0, 1'b0);
        dec.r1       = make_res(8'd0, KIND_ABORT, 7'd0, 1'b1);
        in_frame_nxt = 1'b0;
        cnt_nxt      = '0;
      end else begin
        // unknown escape passes both bytes
        dec.n   = 2'd2;
        dec.r0  = make_res(ByteEsc, KIND_DATA, 7'd0, 1'b0);
        dec.r1  = make_res(rx_byte, KIND_DATA, 7'd0, 1'b1);
        cnt_nxt = cnt_r + 7'd2;
      end
    end else begin
      priority if (rx_byte == ByteSof) begin
        dec.n        = 2'd1;
        dec.r0       = make_res(8'd0, KIND_ABORT, 7'd0, 1'b1);
        in_frame_nxt = 1'b1;
        cnt_nxt      = '0;
      end else if (rx_byte == ByteEof) begin
        dec.n        = 2'd1;
        dec.r0       = make_res(8'd0, KIND_DONE, cnt_r, 1'b1);
        in_frame_nxt = 1'b0;
        cnt_nxt      = '0;
      end else if (rx_byte == ByteEsc) begin
        esc_nxt = 1'b1;
      end else begin
        emit1 = 1'b1;
      end
    end

    if (emit1) begin
      dec.n = 2'd1;
      if (ovf0) begin
        dec.r0       = make_res(8'd0, KIND_ABORT, 7'd0, 1'b1);
        in_frame_nxt = 1'b0;
        esc_nxt      = 1'b0;
        cnt_nxt      = '0;
      end else begin
        dec.r0  = make_res(ebyte, KIND_DATA, 7'd0, 1'b1);
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      cnt_r      <= '0;
    end else if (commit) begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      cnt_r      <= cnt_nxt;
    end
  end
endmodule

// ===== hw/rtl/fsed_obuf.sv =====
// ----------------------------------------------------------------------------
// fsed_obuf
// two entry result register, loaded as a pair and drained one per request
// ----------------------------------------------------------------------------
module fsed_obuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  fsed_pkg::dec_t  dec,
  input  logic            out_ready,
  output logic            out_valid,
  output fsed_pkg::res_t  head,
  output logic            free
);
  import fsed_pkg::*;

  res_t       slot0_r, slot1_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign free      = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign head      = slot0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= dec.n;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0_r <= dec.r0;
      slot1_r <= dec.r1;
    end else if (pop) begin
      slot0_r <= slot1_r;
    end
  end
endmodule

// ===== hw/rtl/fsed_checker.sv =====
// ----------------------------------------------------------------------------
// fsed_checker
// port level checks on the decoder result stream, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsed_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [6:0] frame_length,
  input logic       last,
  input logic       pready
);
  import fsed_pkg::*;

  logic is_data;
  assign is_data = (kind == KIND_DATA);

  // frame end and abort always close the results of their byte
  `FSED_ASSERT(a_ctrl_last, clk, rst_n, (out_valid && !is_data) |-> last)

  // lengths ride only on frame completions
  `FSED_ASSERT(a_len_done, clk, rst_n, (out_valid && (kind != KIND_DONE)) |-> (frame_length == 7'd0))

  // a result held under stall keeps its kind
  `FSED_ASSERT(a_stall_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(kind)))

  `FSED_ASSERT_ALWAYS(a_pready, clk, pready)
endmodule

bind escape_stuffed_frame_decoder_top fsed_checker u_fsed_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .kind         (out_ch.kind),
  .frame_length (out_ch.frame_length),
  .last         (out_ch.last),
  .pready       (pready)
);
